[rtl/ldrlux_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldrlux_pkg
// Shared sizes, constants and types for the light sensor lux averager.
// ----------------------------------------------------------------------------
package ldrlux_pkg;

  // Field widths
  localparam int ADC_W = 10;
  localparam int LUX_W = 16;

  // Lux conversion: lux = LUX_SCALE * adc / (ADC_FULL - adc)
  localparam int LUX_SCALE = 50;
  localparam int ADC_FULL  = 1024;
  localparam int LUX_MAX   = 51150;

  // Averaging window; a power of two, so the mean is a shift of the sum
  localparam int NUM_SAMPLES = 8;
  localparam int PTR_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int SUM_W = LUX_W + $clog2(NUM_SAMPLES);

  // Lux divider sizes: 16-bit quotient, divisor is 1024 - adc
  localparam int DIV_W = LUX_W;
  localparam int DSR_W = ADC_W;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified command: fill flag plus prepared division operands
  typedef struct packed {
    logic             fill;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } cmd_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUX,
    ST_UPDATE,
    ST_SEND
  } state_t;

endpackage

[rtl/ldrlux_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldrlux_div
// Restoring divider, one quotient bit per cycle, used for the lux
// conversion.
// ----------------------------------------------------------------------------
module ldrlux_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ldrlux_pkg::div_req_t req,
  output ldrlux_pkg::div_rsp_t rsp
);
  import ldrlux_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[DSR_W]) begin
        rem_nxt = diff[DSR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DSR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[rtl/ldrlux_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldrlux_front
// Accepts input words, prepares the lux division operands and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
module ldrlux_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [ldrlux_pkg::ADC_W-1:0] in_adc_sample,
  output logic                         cmd_valid,
  output ldrlux_pkg::cmd_t             cmd,
  input  logic                         cmd_pop
);
  import ldrlux_pkg::*;

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;
  logic [ADC_W:0]    den_full;

  // Classify: a zero reading divides zero by one
  always_comb begin
    den_full     = (ADC_W + 1)'(ADC_FULL) - (ADC_W + 1)'(in_adc_sample);
    new_cmd.fill = in_kind;
    if (in_adc_sample == '0) begin
      new_cmd.dividend = '0;
      new_cmd.divisor  = DSR_W'(1);
    end else begin
      new_cmd.dividend = DIV_W'(LUX_W'(LUX_SCALE) * LUX_W'(in_adc_sample));
      new_cmd.divisor  = DSR_W'(den_full[ADC_W-1:0]);
    end
  end

  assign in_stall  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

  // Occupancy never passes the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

endmodule

[rtl/ldrlux_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldrlux_back
// Runs each queued command: lux division, ring update with the mean taken
// as a shift of the window sum, and delivery through the output register.
// ----------------------------------------------------------------------------
module ldrlux_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  ldrlux_pkg::cmd_t             cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ldrlux_pkg::LUX_W-1:0] out_smoothed_lux
);
  import ldrlux_pkg::*;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [LUX_W-1:0]   lux_r;
  logic [LUX_W-1:0]   mean_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [PTR_W-1:0]   pos_r, pos_nxt;
  logic [NUM_SAMPLES-1:0] valid_r, valid_nxt;
  logic [LUX_W-1:0]   fill_r, fill_nxt;
  logic [LUX_W-1:0]   ring_mem [NUM_SAMPLES];
  logic [LUX_W-1:0]   rd_data_r;
  logic [LUX_W-1:0]   old_lux;
  logic               ring_we;
  logic               out_valid_r;
  logic [LUX_W-1:0]   out_data_r;
  logic               lux_ld;
  logic               upd_en;
  logic               mean_ld;
  logic               out_ld;
  logic               out_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  ldrlux_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (cmd_valid) state_nxt = ST_LUX;
      ST_LUX:    if (div_rsp.done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SEND;
      ST_SEND:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_pop          = 1'b0;
    lux_ld           = 1'b0;
    upd_en           = 1'b0;
    mean_ld          = 1'b0;
    out_ld           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cmd.dividend;
    div_req.divisor  = cmd.divisor;
    case (state_r)
      ST_IDLE: begin
        cmd_pop       = cmd_valid;
        div_req.start = cmd_valid;
      end
      ST_LUX: lux_ld = div_rsp.done;
      ST_UPDATE: begin
        upd_en  = 1'b1;
        mean_ld = 1'b1;
      end
      ST_SEND: out_ld = out_free;
      default: cmd_pop = 1'b0;
    endcase
  end

  // Ring update: replace one slot or fill them all
  always_comb begin
    old_lux   = valid_r[pos_r] ? rd_data_r : fill_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    ring_we   = 1'b0;
    if (upd_en) begin
      if (cmd_r.fill) begin
        sum_nxt   = SUM_W'(lux_r) * SUM_W'(NUM_SAMPLES);
        valid_nxt = '0;
        fill_nxt  = lux_r;
      end else begin
        sum_nxt          = sum_r - SUM_W'(old_lux) + SUM_W'(lux_r);
        valid_nxt[pos_r] = 1'b1;
        ring_we          = 1'b1;
        pos_nxt = (pos_r == PTR_W'(NUM_SAMPLES - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      pos_r       <= '0;
      valid_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payload; the truncated mean is the new sum shifted by the ring size
  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    if (lux_ld) lux_r <= div_rsp.quotient[LUX_W-1:0];
    if (mean_ld) mean_r <= LUX_W'(sum_nxt / SUM_W'(NUM_SAMPLES));
    if (out_ld) out_data_r <= mean_r;
  end

  // Ring storage, registered read at the write slot
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[pos_r] <= lux_r;
    rd_data_r <= ring_mem[pos_r];
  end

  assign out_valid        = out_valid_r;
  assign out_smoothed_lux = out_data_r;

  // Divider only answers while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_LUX))
    else $error("divider result outside a wait state");

  // Window sum stays within a full ring of full-scale values
  assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(NUM_SAMPLES * LUX_MAX))
    else $error("window sum out of range");

  // Slot pointer stays inside the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PTR_W'(NUM_SAMPLES - 1))
    else $error("ring pointer out of range");

  // A delivered mean shows up on the output next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (out_valid_r && out_smoothed_lux == $past(mean_r)))
    else $error("result not presented after load");

  // Fast fill leaves no slot marked as individually written
  assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && cmd_r.fill) |=> (valid_r == '0 && fill_r == $past(lux_r)))
    else $error("fast fill did not reset the ring");

endmodule

[rtl/ldr_lux_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldr_lux_moving_average
// Light sensor reading to lux conversion with a moving-average window.
// ----------------------------------------------------------------------------
// Each word carries a 10-bit converter reading and a kind bit. The reading
// becomes lux = floor(50*adc/(1024-adc)), zero for a zero reading; kind 0
// writes it into the next ring slot, kind 1 writes it into every slot. Each
// word yields one word: the truncated mean of the eight-slot ring. The back
// end works on one word at a time and pops the next only after the mean of
// the last is loaded into the result register, which waits while the
// output is stalled. The lux quotient comes from a bit-serial divider; the
// mean is a shift of the running window sum. A two-word queue takes input
// while the back end is busy, and the result register holds a mean while
// the next word is accepted. After reset the ring reads as zero; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module ldr_lux_moving_average (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [ldrlux_pkg::ADC_W-1:0] in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ldrlux_pkg::LUX_W-1:0] out_smoothed_lux
);
  import ldrlux_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Accept and classify
  ldrlux_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_adc_sample (in_adc_sample),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Convert, average and deliver
  ldrlux_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_smoothed_lux (out_smoothed_lux)
  );

endmodule
